// ===== rtl/fat12te_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and constants of the FAT12 table engine.
package fat12te_pkg;

    typedef enum logic [2:0] {
        OP_LOAD_BYTE  = 3'd0,
        OP_READ_ENTRY = 3'd1,
        OP_WRITE_ENTRY = 3'd2,
        OP_FREE_CHAIN = 3'd3,
        OP_FIND_FREE  = 3'd4,
        OP_READ_BYTE  = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_NO_FREE  = 2'd2,
        ST_LOOP     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        MA_BYTE,
        MA_LO,
        MA_HI
    } mem_sel_t;

    typedef enum logic [2:0] {
        RES_ZERO,
        RES_RANGE,
        RES_NO_FREE,
        RES_LOOP,
        RES_ENTRY,
        RES_FOUND,
        RES_BYTE
    } res_kind_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_RD_BYTE,
        S_RD_LO,
        S_RD_HI,
        S_EVAL,
        S_WR_HI,
        S_CH_CHECK,
        S_SR_CHECK,
        S_FINISH
    } state_t;

    localparam logic [11:0] END_MARK       = 12'hFF8;
    localparam logic [12:0] FIRST_SEARCH   = 13'd2;
    localparam logic [12:0] COUNT_RESET    = 13'd3072;

    typedef struct packed {
        logic      cap;
        logic      rd_en;
        logic      wr_en;
        mem_sel_t  addr_sel;
        logic      lo_latch;
        logic      next_latch;
        logic      cur_load_next;
        logic      cur_load_first;
        logic      cur_inc;
        logic      res_set;
        res_kind_t res_kind;
        logic      out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       addr_ok;
        logic       cur_ok;
        logic       steps_lt;
        logic       count_zero;
        logic       entry_zero;
        logic       next_end;
        logic       out_free;
    } dp_stat_t;

endpackage

// ===== rtl/fat12_table_engine.sv =====
`timescale 1ns / 1ps
// Top level of the FAT12 table engine: packed 12-bit allocation table with chain operations.
//
//  channel  | handshake             | beat contents
//  ---------+-----------------------+-----------------------------------------------
//  input    | in_valid / in_ready   | operation, entry_index, entry_value,
//           |                       | byte_address, byte_data
//  output   | out_valid / out_ready | entry_out, byte_out, status
//  config   | cfg_write             | cfg_data (entry_count)
//
// Every operation goes through a single-port byte store, one access per cycle: a byte
// load writes at dispatch, a byte read reads once, an entry read or write reads both
// bytes of the entry and a write writes them back; a chain free or free search repeats
// that entry step after a check for each link or entry. A walk or search that fails
// ends on its check step; an out-of-range byte or entry request finishes at dispatch.
// Reset clears the sequencer, the output valid flag and sets entry_count to 3072;
// the byte store is not cleared and must be loaded before entries are used.
// A new input beat is taken as soon as the sequencer is idle, even while the last
// result still waits in the output register; a stalled output only holds the next
// result in its finish step.
module fat12_table_engine #(
    parameter int TABLE_BYTES = 6144
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [12:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  operation,
    input  logic [11:0] entry_index,
    input  logic [11:0] entry_value,
    input  logic [12:0] byte_address,
    input  logic [7:0]  byte_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [11:0] entry_out,
    output logic [7:0]  byte_out,
    output logic [1:0]  status
);

    // Commands flow from the sequencer to the datapath, flags flow back.
    fat12te_pkg::dp_cmd_t  cmd;
    fat12te_pkg::dp_stat_t stat;

    fat12te_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath owns the byte store, the walk registers for chains and searches,
    // and the result register that decouples the output side.
    fat12te_dp #(
        .TABLE_BYTES (TABLE_BYTES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .operation    (operation),
        .entry_index  (entry_index),
        .entry_value  (entry_value),
        .byte_address (byte_address),
        .byte_data    (byte_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .entry_out    (entry_out),
        .byte_out     (byte_out),
        .status       (status),
        .cmd          (cmd),
        .stat         (stat)
    );

endmodule

// ===== rtl/fat12te_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencing state machine of the FAT12 table engine.
module fat12te_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  fat12te_pkg::dp_stat_t stat,
    output fat12te_pkg::dp_cmd_t  cmd
);

    fat12te_pkg::state_t state_reg;
    fat12te_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fat12te_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fat12te_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = fat12te_pkg::S_DISPATCH;
                end
            end
            fat12te_pkg::S_DISPATCH:
            begin
                case (stat.op)
                    fat12te_pkg::OP_READ_BYTE:
                    begin
                        state_next = stat.addr_ok ? fat12te_pkg::S_RD_BYTE
                                                  : fat12te_pkg::S_FINISH;
                    end
                    fat12te_pkg::OP_READ_ENTRY, fat12te_pkg::OP_WRITE_ENTRY:
                    begin
                        state_next = stat.cur_ok ? fat12te_pkg::S_RD_LO
                                                 : fat12te_pkg::S_FINISH;
                    end
                    fat12te_pkg::OP_FREE_CHAIN: state_next = fat12te_pkg::S_CH_CHECK;
                    fat12te_pkg::OP_FIND_FREE:  state_next = fat12te_pkg::S_SR_CHECK;
                    default:                    state_next = fat12te_pkg::S_FINISH;
                endcase
            end
            fat12te_pkg::S_RD_BYTE: state_next = fat12te_pkg::S_FINISH;
            fat12te_pkg::S_RD_LO:   state_next = fat12te_pkg::S_RD_HI;
            fat12te_pkg::S_RD_HI:   state_next = fat12te_pkg::S_EVAL;
            fat12te_pkg::S_EVAL:
            begin
                case (stat.op)
                    fat12te_pkg::OP_WRITE_ENTRY, fat12te_pkg::OP_FREE_CHAIN:
                    begin
                        state_next = fat12te_pkg::S_WR_HI;
                    end
                    fat12te_pkg::OP_FIND_FREE:
                    begin
                        state_next = stat.entry_zero ? fat12te_pkg::S_FINISH
                                                     : fat12te_pkg::S_SR_CHECK;
                    end
                    default: state_next = fat12te_pkg::S_FINISH;
                endcase
            end
            fat12te_pkg::S_WR_HI:
            begin
                if (stat.op == fat12te_pkg::OP_FREE_CHAIN && !stat.next_end)
                begin
                    state_next = fat12te_pkg::S_CH_CHECK;
                end
                else
                begin
                    state_next = fat12te_pkg::S_FINISH;
                end
            end
            fat12te_pkg::S_CH_CHECK:
            begin
                state_next = (stat.steps_lt && stat.cur_ok) ? fat12te_pkg::S_RD_LO
                                                            : fat12te_pkg::S_FINISH;
            end
            fat12te_pkg::S_SR_CHECK:
            begin
                state_next = stat.cur_ok ? fat12te_pkg::S_RD_LO : fat12te_pkg::S_FINISH;
            end
            fat12te_pkg::S_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = fat12te_pkg::S_IDLE;
                end
            end
            default: state_next = fat12te_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            fat12te_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.cap  = in_valid;
            end
            fat12te_pkg::S_DISPATCH:
            begin
                case (stat.op)
                    fat12te_pkg::OP_LOAD_BYTE:
                    begin
                        cmd.addr_sel = fat12te_pkg::MA_BYTE;
                        cmd.wr_en    = stat.addr_ok;
                        cmd.res_set  = 1'b1;
                        cmd.res_kind = stat.addr_ok ? fat12te_pkg::RES_ZERO
                                                    : fat12te_pkg::RES_RANGE;
                    end
                    fat12te_pkg::OP_READ_BYTE:
                    begin
                        cmd.addr_sel = fat12te_pkg::MA_BYTE;
                        cmd.rd_en    = stat.addr_ok;
                        cmd.res_set  = !stat.addr_ok;
                        cmd.res_kind = fat12te_pkg::RES_RANGE;
                    end
                    fat12te_pkg::OP_READ_ENTRY, fat12te_pkg::OP_WRITE_ENTRY:
                    begin
                        cmd.res_set  = !stat.cur_ok;
                        cmd.res_kind = fat12te_pkg::RES_RANGE;
                    end
                    fat12te_pkg::OP_FREE_CHAIN:
                    begin
                    end
                    fat12te_pkg::OP_FIND_FREE:
                    begin
                        cmd.cur_load_first = 1'b1;
                    end
                    default:
                    begin
                        cmd.res_set  = 1'b1;
                        cmd.res_kind = fat12te_pkg::RES_ZERO;
                    end
                endcase
            end
            fat12te_pkg::S_RD_BYTE:
            begin
                cmd.res_set  = 1'b1;
                cmd.res_kind = fat12te_pkg::RES_BYTE;
            end
            fat12te_pkg::S_RD_LO:
            begin
                cmd.rd_en    = 1'b1;
                cmd.addr_sel = fat12te_pkg::MA_LO;
            end
            fat12te_pkg::S_RD_HI:
            begin
                cmd.rd_en    = 1'b1;
                cmd.addr_sel = fat12te_pkg::MA_HI;
                cmd.lo_latch = 1'b1;
            end
            fat12te_pkg::S_EVAL:
            begin
                case (stat.op)
                    fat12te_pkg::OP_WRITE_ENTRY:
                    begin
                        cmd.wr_en    = 1'b1;
                        cmd.addr_sel = fat12te_pkg::MA_LO;
                    end
                    fat12te_pkg::OP_FREE_CHAIN:
                    begin
                        cmd.wr_en      = 1'b1;
                        cmd.addr_sel   = fat12te_pkg::MA_LO;
                        cmd.next_latch = 1'b1;
                    end
                    fat12te_pkg::OP_FIND_FREE:
                    begin
                        cmd.res_set  = stat.entry_zero;
                        cmd.res_kind = fat12te_pkg::RES_FOUND;
                        cmd.cur_inc  = !stat.entry_zero;
                    end
                    default:
                    begin
                        cmd.res_set  = 1'b1;
                        cmd.res_kind = fat12te_pkg::RES_ENTRY;
                    end
                endcase
            end
            fat12te_pkg::S_WR_HI:
            begin
                cmd.wr_en    = 1'b1;
                cmd.addr_sel = fat12te_pkg::MA_HI;
                if (stat.op == fat12te_pkg::OP_FREE_CHAIN && !stat.next_end)
                begin
                    cmd.cur_load_next = 1'b1;
                end
                else
                begin
                    cmd.res_set  = 1'b1;
                    cmd.res_kind = fat12te_pkg::RES_ZERO;
                end
            end
            fat12te_pkg::S_CH_CHECK:
            begin
                if (!stat.steps_lt)
                begin
                    // An empty table bound reports a range error, a long walk a loop.
                    cmd.res_set  = 1'b1;
                    cmd.res_kind = stat.count_zero ? fat12te_pkg::RES_RANGE
                                                   : fat12te_pkg::RES_LOOP;
                end
                else if (!stat.cur_ok)
                begin
                    cmd.res_set  = 1'b1;
                    cmd.res_kind = fat12te_pkg::RES_RANGE;
                end
            end
            fat12te_pkg::S_SR_CHECK:
            begin
                cmd.res_set  = !stat.cur_ok;
                cmd.res_kind = fat12te_pkg::RES_NO_FREE;
            end
            fat12te_pkg::S_FINISH:
            begin
                cmd.out_load = stat.out_free;
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== rtl/fat12te_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the FAT12 table engine: byte store, entry packing and result registers.
module fat12te_dp #(
    parameter int TABLE_BYTES = 6144
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [12:0]           cfg_data,
    input  logic [2:0]            operation,
    input  logic [11:0]           entry_index,
    input  logic [11:0]           entry_value,
    input  logic [12:0]           byte_address,
    input  logic [7:0]            byte_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [11:0]           entry_out,
    output logic [7:0]            byte_out,
    output logic [1:0]            status,
    input  fat12te_pkg::dp_cmd_t  cmd,
    output fat12te_pkg::dp_stat_t stat
);

    localparam int AW = (TABLE_BYTES > 1) ? $clog2(TABLE_BYTES) : 1;
    localparam logic [13:0] TB = 14'(TABLE_BYTES);

    logic [7:0]  mem [TABLE_BYTES];

    logic [12:0] count_reg;
    logic [2:0]  op_reg;
    logic [11:0] val_reg;
    logic [12:0] addr_reg;
    logic [7:0]  data_reg;
    logic [12:0] cur_reg;
    logic [12:0] steps_reg;
    logic [11:0] next_reg;
    logic [7:0]  lo_reg;
    logic [7:0]  rd_data_reg;
    logic [11:0] res_entry_reg;
    logic [7:0]  res_byte_reg;
    logic [1:0]  res_status_reg;
    logic        out_valid_reg;
    logic [11:0] out_entry_reg;
    logic [7:0]  out_byte_reg;
    logic [1:0]  out_status_reg;

    logic [11:0] res_entry_next;
    logic [7:0]  res_byte_next;
    logic [1:0]  res_status_next;

    logic [13:0] a0;
    logic [13:0] a1;
    logic [13:0] mem_addr;
    logic [7:0]  mem_wdata;
    logic [15:0] word;
    logic [11:0] entry;
    logic [11:0] wval;
    logic [7:0]  lo_wr;
    logic [7:0]  hi_wr;
    logic        odd;

    // Entry k starts at byte k + k/2.
    assign a0   = {1'b0, cur_reg} + {2'b00, cur_reg[12:1]};
    assign a1   = a0 + 14'd1;
    assign odd  = cur_reg[0];
    assign word = {rd_data_reg, lo_reg};
    assign entry = odd ? word[15:4] : word[11:0];
    assign wval = (op_reg == fat12te_pkg::OP_WRITE_ENTRY) ? val_reg : 12'd0;
    assign lo_wr = odd ? {wval[3:0], lo_reg[3:0]} : wval[7:0];
    assign hi_wr = odd ? wval[11:4] : {rd_data_reg[7:4], wval[11:8]};

    always_comb
    begin
        case (cmd.addr_sel)
            fat12te_pkg::MA_LO:
            begin
                mem_addr  = a0;
                mem_wdata = lo_wr;
            end
            fat12te_pkg::MA_HI:
            begin
                mem_addr  = a1;
                mem_wdata = hi_wr;
            end
            default:
            begin
                mem_addr  = {1'b0, addr_reg};
                mem_wdata = data_reg;
            end
        endcase
    end

    always_comb
    begin
        res_entry_next  = 12'd0;
        res_byte_next   = 8'd0;
        res_status_next = fat12te_pkg::ST_OK;
        case (cmd.res_kind)
            fat12te_pkg::RES_RANGE:   res_status_next = fat12te_pkg::ST_RANGE;
            fat12te_pkg::RES_NO_FREE: res_status_next = fat12te_pkg::ST_NO_FREE;
            fat12te_pkg::RES_LOOP:    res_status_next = fat12te_pkg::ST_LOOP;
            fat12te_pkg::RES_ENTRY:   res_entry_next  = entry;
            fat12te_pkg::RES_FOUND:   res_entry_next  = cur_reg[11:0];
            fat12te_pkg::RES_BYTE:    res_byte_next   = rd_data_reg;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[mem_addr[AW-1:0]] <= mem_wdata;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[mem_addr[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= fat12te_pkg::COUNT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                count_reg <= cfg_data;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            op_reg    <= operation;
            val_reg   <= entry_value;
            addr_reg  <= byte_address;
            data_reg  <= byte_data;
            cur_reg   <= {1'b0, entry_index};
            steps_reg <= 13'd0;
        end
        else
        begin
            if (cmd.cur_load_first)
            begin
                cur_reg <= fat12te_pkg::FIRST_SEARCH;
            end
            else if (cmd.cur_load_next)
            begin
                cur_reg <= {1'b0, next_reg};
            end
            else if (cmd.cur_inc)
            begin
                cur_reg <= cur_reg + 13'd1;
            end
            if (cmd.next_latch)
            begin
                next_reg  <= entry;
                steps_reg <= steps_reg + 13'd1;
            end
        end
        if (cmd.lo_latch)
        begin
            lo_reg <= rd_data_reg;
        end
        if (cmd.res_set)
        begin
            res_entry_reg  <= res_entry_next;
            res_byte_reg   <= res_byte_next;
            res_status_reg <= res_status_next;
        end
        if (cmd.out_load)
        begin
            out_entry_reg  <= res_entry_reg;
            out_byte_reg   <= res_byte_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign stat.op         = op_reg;
    assign stat.addr_ok    = {1'b0, addr_reg} < TB;
    assign stat.cur_ok     = (cur_reg < count_reg) && (a1 < TB);
    assign stat.steps_lt   = steps_reg < count_reg;
    assign stat.count_zero = (count_reg == 13'd0);
    assign stat.entry_zero = (entry == 12'd0);
    assign stat.next_end   = (next_reg >= fat12te_pkg::END_MARK);
    assign stat.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign entry_out = out_entry_reg;
    assign byte_out  = out_byte_reg;
    assign status    = out_status_reg;

endmodule

// ===== test/fat12_table_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the FAT12 table engine: mirrors the packed table and checks every result beat.
module fat12_table_checker #(
    parameter int TABLE_BYTES = 6144
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [12:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [2:0]  operation,
    input  logic [11:0] entry_index,
    input  logic [11:0] entry_value,
    input  logic [12:0] byte_address,
    input  logic [7:0]  byte_data,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [11:0] entry_out,
    input  logic [7:0]  byte_out,
    input  logic [1:0]  status,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [11:0]          entry;
        logic [7:0]           data;
        fat12te_pkg::status_t code;
    } table_result_t;

    logic [7:0]    shadow_bytes [TABLE_BYTES];
    logic [12:0]   shadow_count;
    table_result_t result_queue [$];
    int            errors = 0;

    function automatic bit in_table(input int k);
        return (k < int'(shadow_count)) && ((k * 3) / 2 + 1 < TABLE_BYTES);
    endfunction

    function automatic logic [11:0] cluster_value(input int k);
        int          a;
        logic [15:0] word;
        a = (k * 3) / 2;
        word = {shadow_bytes[a + 1], shadow_bytes[a]};
        return k[0] ? word[15:4] : word[11:0];
    endfunction

    // Only the twelve bits of the addressed entry change; the shared nibble keeps its neighbor.
    function automatic void cluster_store(input int k, input logic [11:0] v);
        int a;
        a = (k * 3) / 2;
        if (k[0])
        begin
            shadow_bytes[a] = {v[3:0], shadow_bytes[a][3:0]};
            shadow_bytes[a + 1] = v[11:4];
        end
        else
        begin
            shadow_bytes[a] = v[7:0];
            shadow_bytes[a + 1] = {shadow_bytes[a + 1][7:4], v[11:8]};
        end
    endfunction

    function automatic table_result_t apply_beat(input logic [2:0] op, input int idx,
                                                 input int val, input int addr,
                                                 input logic [7:0] data);
        table_result_t r;
        int            cur;
        int            steps;
        int            nxt;
        int            k;
        bit            done;
        r.entry = '0;
        r.data = '0;
        r.code = fat12te_pkg::ST_OK;
        done = 1'b0;
        case (op)
            fat12te_pkg::OP_LOAD_BYTE:
                if (addr < TABLE_BYTES)
                    shadow_bytes[addr] = data;
                else
                    r.code = fat12te_pkg::ST_RANGE;
            fat12te_pkg::OP_READ_BYTE:
                if (addr < TABLE_BYTES)
                    r.data = shadow_bytes[addr];
                else
                    r.code = fat12te_pkg::ST_RANGE;
            fat12te_pkg::OP_READ_ENTRY:
                if (in_table(idx))
                    r.entry = cluster_value(idx);
                else
                    r.code = fat12te_pkg::ST_RANGE;
            fat12te_pkg::OP_WRITE_ENTRY:
                if (in_table(idx))
                    cluster_store(idx, 12'(val));
                else
                    r.code = fat12te_pkg::ST_RANGE;
            fat12te_pkg::OP_FREE_CHAIN:
            begin
                cur = idx;
                steps = 0;
                r.code = fat12te_pkg::ST_LOOP;
                while (!done && steps < int'(shadow_count))
                begin
                    if (!in_table(cur))
                    begin
                        r.code = fat12te_pkg::ST_RANGE;
                        done = 1'b1;
                    end
                    else
                    begin
                        nxt = cluster_value(cur);
                        cluster_store(cur, 12'd0);
                        steps++;
                        if (nxt >= int'(fat12te_pkg::END_MARK))
                        begin
                            r.code = fat12te_pkg::ST_OK;
                            done = 1'b1;
                        end
                        cur = nxt;
                    end
                end
                if (shadow_count == 0)
                    r.code = fat12te_pkg::ST_RANGE;
            end
            fat12te_pkg::OP_FIND_FREE:
            begin
                r.code = fat12te_pkg::ST_NO_FREE;
                k = int'(fat12te_pkg::FIRST_SEARCH);
                while (!done && in_table(k))
                begin
                    if (cluster_value(k) == 12'd0)
                    begin
                        r.entry = 12'(k);
                        r.code = fat12te_pkg::ST_OK;
                        done = 1'b1;
                    end
                    k++;
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        table_result_t want;
        if (!rst_n)
        begin
            shadow_count = fat12te_pkg::COUNT_RESET;
            result_queue.delete();
        end
        else
        begin
            // A result beat always belongs to an input beat taken at an earlier edge.
            if (out_valid && out_ready)
            begin
                if (result_queue.size() == 0)
                begin
                    $error("result beat with nothing expected: %s %0d %s %0d %s %0d",
                           "entry_out", entry_out, "byte_out", byte_out,
                           "status", status);
                    errors++;
                end
                else
                begin
                    want = result_queue.pop_front();
                    if (entry_out !== want.entry)
                    begin
                        $error("entry_out: expected %0d, actual %0d", want.entry, entry_out);
                        errors++;
                    end
                    if (byte_out !== want.data)
                    begin
                        $error("byte_out: expected %0d, actual %0d", want.data, byte_out);
                        errors++;
                    end
                    if (status !== want.code)
                    begin
                        $error("status: expected %0d, actual %0d", want.code, status);
                        errors++;
                    end
                end
            end
            if (in_valid && in_ready)
                result_queue.push_back(apply_beat(operation, int'(entry_index),
                                                  int'(entry_value), int'(byte_address),
                                                  byte_data));
            if (cfg_write)
                shadow_count = cfg_data;
        end
        fail_count <= errors;
        pending <= result_queue.size();
    end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the FAT12 table engine: clock, reset, stimulus phases and the verdict.
module tb_top;

    localparam int TABLE_BYTES = 6144;
    // Only the first LOADED_ENTRIES entries and the last three bytes of the store are
    // loaded, so every later read stays inside loaded bytes.
    localparam int LOADED_ENTRIES = 128;
    localparam int LOADED_BYTES = LOADED_ENTRIES * 3 / 2;
    // Codes outside the operation set; the engine must answer them with an all-zero result.
    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;
    localparam logic [11:0] RESERVED_MARK = 12'hFFF;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASE_ITEMS = 160;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic [12:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  operation = '0;
    logic [11:0] entry_index = '0;
    logic [11:0] entry_value = '0;
    logic [12:0] byte_address = '0;
    logic [7:0]  byte_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [11:0] entry_out;
    logic [7:0]  byte_out;
    logic [1:0]  status;

    int fail_count;
    int pending;
    // The stimulus side keeps its own copy of entry_count so that chains stay inside the table.
    int entry_limit = int'(fat12te_pkg::COUNT_RESET);
    int items_done = 0;
    // Set near the end of the run: from then on neither side idles.
    bit quiet = 1'b0;

    always #10 clk = ~clk;

    fat12_table_engine #(
        .TABLE_BYTES(TABLE_BYTES)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .operation(operation),
        .entry_index(entry_index),
        .entry_value(entry_value),
        .byte_address(byte_address),
        .byte_data(byte_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .entry_out(entry_out),
        .byte_out(byte_out),
        .status(status)
    );

    fat12_table_checker #(
        .TABLE_BYTES(TABLE_BYTES)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .operation(operation),
        .entry_index(entry_index),
        .entry_value(entry_value),
        .byte_address(byte_address),
        .byte_data(byte_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .entry_out(entry_out),
        .byte_out(byte_out),
        .status(status),
        .fail_count(fail_count),
        .pending(pending)
    );

    // Result side: stalls come in bursts between stretches of readiness, so that they
    // land on every step of the engine's sequencer, including the finish step that holds
    // a result while the previous one waits.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(0, 24)) @(posedge clk);
        end
    end

    // Sends one input beat and returns at the edge where it is taken. Fields that the
    // operation does not use carry random values, which also exercises their bits.
    task automatic push_beat(input logic [2:0] op, input int idx, input int val,
                             input int addr, input int data);
        bit wants_entry;
        bit wants_value;
        bit wants_byte;
        wants_entry = (op == fat12te_pkg::OP_READ_ENTRY) || (op == fat12te_pkg::OP_WRITE_ENTRY)
                      || (op == fat12te_pkg::OP_FREE_CHAIN);
        wants_value = (op == fat12te_pkg::OP_WRITE_ENTRY);
        wants_byte = (op == fat12te_pkg::OP_LOAD_BYTE) || (op == fat12te_pkg::OP_READ_BYTE);
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        entry_index <= wants_entry ? 12'(idx) : 12'($urandom_range(0, 4095));
        entry_value <= wants_value ? 12'(val) : 12'($urandom_range(0, 4095));
        byte_address <= wants_byte ? 13'(addr) : 13'($urandom_range(0, 8191));
        byte_data <= (op == fat12te_pkg::OP_LOAD_BYTE) ? 8'(data) : 8'($urandom_range(0, 255));
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_done++;
    endtask

    // Holds the sender back until every result beat has come out. It first waits for a clock
    // edge so that the checker has counted the beat taken at the current edge.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_entry_count(input int count);
        settle();
        cfg_write <= 1'b1;
        cfg_data <= 13'(count);
        entry_limit = count;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Entries 0 and 1 hold end marks, as in a formatted table. A walk that runs into a
    // freed entry then stops at entry 0 instead of spinning there for entry_count steps.
    task automatic restore_reserved();
        push_beat(fat12te_pkg::OP_WRITE_ENTRY, 0, RESERVED_MARK, 0, 0);
        push_beat(fat12te_pkg::OP_WRITE_ENTRY, 1, RESERVED_MARK, 0, 0);
    endtask

    // A file's cluster chain: distinct entries linked in order and closed by an end mark.
    // Most chains are freed again, from the head or from a link inside the chain.
    task automatic chain_sequence();
        int  len;
        int  nodes [8];
        bit  clash;
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++)
        begin
            do
            begin
                nodes[i] = $urandom_range(2, entry_limit - 1);
                clash = 1'b0;
                for (int j = 0; j < i; j++)
                    if (nodes[j] == nodes[i])
                        clash = 1'b1;
            end while (clash);
        end
        for (int i = 0; i < len; i++)
        begin
            if (i == len - 1)
                push_beat(fat12te_pkg::OP_WRITE_ENTRY, nodes[i],
                          $urandom_range(fat12te_pkg::END_MARK, 12'hFFF), 0, 0);
            else
                push_beat(fat12te_pkg::OP_WRITE_ENTRY, nodes[i], nodes[i + 1], 0, 0);
        end
        if ($urandom_range(0, 1) == 0)
            push_beat(fat12te_pkg::OP_READ_ENTRY, nodes[$urandom_range(0, len - 1)], 0, 0, 0);
        if ($urandom_range(0, 4) != 0)
        begin
            push_beat(fat12te_pkg::OP_FREE_CHAIN, nodes[$urandom_range(0, len - 1)], 0, 0, 0);
            push_beat(fat12te_pkg::OP_READ_ENTRY, nodes[len - 1], 0, 0, 0);
        end
    endtask

    function automatic logic [11:0] fresh_cluster();
        return ($urandom_range(0, 7) == 0) ? 12'd0 : 12'($urandom_range(1, 4095));
    endfunction

    // Loads the three bytes that hold entries 2p and 2p + 1.
    task automatic load_triplet(input int p);
        logic [11:0] even_cl;
        logic [11:0] odd_cl;
        even_cl = (p == 0) ? RESERVED_MARK : fresh_cluster();
        odd_cl = (p == 0) ? RESERVED_MARK : fresh_cluster();
        push_beat(fat12te_pkg::OP_LOAD_BYTE, 0, 0, 3 * p, even_cl[7:0]);
        push_beat(fat12te_pkg::OP_LOAD_BYTE, 0, 0, 3 * p + 1, {odd_cl[3:0], even_cl[11:8]});
        push_beat(fat12te_pkg::OP_LOAD_BYTE, 0, 0, 3 * p + 2, odd_cl[11:4]);
    endtask

    initial
    begin
        logic [2:0]  op;
        int          phase_counts [5];
        int          goal;
        int          pick;
        int          idx;
        int          addr;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The byte store powers up undefined, so every byte that the run reads is loaded first.
        // Entries get random values, about one in eight of them free. Besides the low
        // part of the table, the last three bytes are loaded for the top entries.
        for (int p = 0; p < LOADED_ENTRIES / 2; p++)
            load_triplet(p);
        load_triplet(TABLE_BYTES / 3 - 1);

        // Directed part at the reset entry_count: byte addresses at both ends and past the
        // store, entries at the count boundary, nibble sharing between even and odd entries,
        // a chain that ends normally, one that leaves the table, and the spare codes.
        push_beat(fat12te_pkg::OP_READ_BYTE, 0, 0, 0, 0);
        push_beat(fat12te_pkg::OP_READ_BYTE, 0, 0, TABLE_BYTES - 1, 0);
        push_beat(fat12te_pkg::OP_READ_BYTE, 0, 0, TABLE_BYTES, 0);
        push_beat(fat12te_pkg::OP_READ_BYTE, 0, 0, 8191, 0);
        push_beat(fat12te_pkg::OP_LOAD_BYTE, 0, 0, 8191, 8'hFF);
        push_beat(fat12te_pkg::OP_LOAD_BYTE, 0, 0, TABLE_BYTES, 8'h00);
        push_beat(fat12te_pkg::OP_READ_ENTRY, 0, 0, 0, 0);
        push_beat(fat12te_pkg::OP_READ_ENTRY, LOADED_ENTRIES - 1, 0, 0, 0);
        push_beat(fat12te_pkg::OP_READ_ENTRY, entry_limit, 0, 0, 0);
        push_beat(fat12te_pkg::OP_READ_ENTRY, 4095, 0, 0, 0);
        push_beat(fat12te_pkg::OP_WRITE_ENTRY, 5, 12'hFFF, 0, 0);
        push_beat(fat12te_pkg::OP_WRITE_ENTRY, 6, 12'h000, 0, 0);
        push_beat(fat12te_pkg::OP_WRITE_ENTRY, 4095, 12'hABC, 0, 0);
        push_beat(fat12te_pkg::OP_READ_ENTRY, 5, 0, 0, 0);
        push_beat(fat12te_pkg::OP_READ_ENTRY, 6, 0, 0, 0);
        push_beat(fat12te_pkg::OP_WRITE_ENTRY, 10, 11, 0, 0);
        push_beat(fat12te_pkg::OP_WRITE_ENTRY, 11, fat12te_pkg::END_MARK, 0, 0);
        push_beat(fat12te_pkg::OP_FREE_CHAIN, 10, 0, 0, 0);
        push_beat(fat12te_pkg::OP_READ_ENTRY, 11, 0, 0, 0);
        push_beat(fat12te_pkg::OP_FREE_CHAIN, entry_limit, 0, 0, 0);
        push_beat(fat12te_pkg::OP_WRITE_ENTRY, 12, 3500, 0, 0);
        push_beat(fat12te_pkg::OP_FREE_CHAIN, 12, 0, 0, 0);
        push_beat(fat12te_pkg::OP_FIND_FREE, 0, 0, 0, 0);
        push_beat(OP_SPARE_LO, 0, 0, 0, 0);
        push_beat(OP_SPARE_HI, 0, 0, 0, 0);

        // Largest table: the very last entry is now in range.
        set_entry_count(4096);
        push_beat(fat12te_pkg::OP_READ_ENTRY, 4095, 0, 0, 0);
        push_beat(fat12te_pkg::OP_WRITE_ENTRY, 4095, 12'hFF8, 0, 0);
        push_beat(fat12te_pkg::OP_READ_ENTRY, 4095, 0, 0, 0);

        // Smallest table: the free search has nothing to scan.
        set_entry_count(2);
        push_beat(fat12te_pkg::OP_FIND_FREE, 0, 0, 0, 0);
        push_beat(fat12te_pkg::OP_READ_ENTRY, 1, 0, 0, 0);
        push_beat(fat12te_pkg::OP_READ_ENTRY, 2, 0, 0, 0);
        push_beat(fat12te_pkg::OP_FREE_CHAIN, 2, 0, 0, 0);

        // Entries 0 and 2 point at each other, so the walk never meets an end mark and
        // stops on the step limit.
        set_entry_count(3);
        push_beat(fat12te_pkg::OP_WRITE_ENTRY, 0, 2, 0, 0);
        push_beat(fat12te_pkg::OP_WRITE_ENTRY, 2, 0, 0, 0);
        push_beat(fat12te_pkg::OP_FREE_CHAIN, 2, 0, 0, 0);
        restore_reserved();

        // A full small table: every searchable entry is taken.
        set_entry_count(6);
        for (int k = 2; k < 6; k++)
            push_beat(fat12te_pkg::OP_WRITE_ENTRY, k, int'(fat12te_pkg::END_MARK) + k, 0, 0);
        push_beat(fat12te_pkg::OP_FIND_FREE, 0, 0, 0, 0);

        // Random phases, each at its own table size within the loaded entries. Most traffic
        // is chain building and freeing; the rest is entry and byte traffic, boundary probes
        // and raw noise.
        phase_counts[0] = LOADED_ENTRIES;
        phase_counts[1] = 40;
        phase_counts[2] = $urandom_range(12, LOADED_ENTRIES);
        phase_counts[3] = 100;
        phase_counts[4] = 64;
        goal = items_done;
        for (int ph = 0; ph < 5; ph++)
        begin
            set_entry_count(phase_counts[ph]);
            goal += PHASE_ITEMS;
            while (items_done < goal)
            begin
                if (ph == 4 && items_done >= goal - 100)
                    quiet = 1'b1;
                pick = $urandom_range(0, 99);
                if (pick < 35)
                begin
                    chain_sequence();
                end
                else if (pick < 47)
                begin
                    push_beat(fat12te_pkg::OP_FIND_FREE, 0, 0, 0, 0);
                end
                else if (pick < 62)
                begin
                    idx = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 4095)
                                                     : $urandom_range(2, entry_limit - 1);
                    op = ($urandom_range(0, 1) == 0) ? fat12te_pkg::OP_READ_ENTRY
                                                    : fat12te_pkg::OP_WRITE_ENTRY;
                    push_beat(op, idx, $urandom_range(0, 4095), 0, 0);
                end
                else if (pick < 77)
                begin
                    addr = ($urandom_range(0, 7) == 0) ? $urandom_range(TABLE_BYTES, 8191)
                                                      : $urandom_range(0, LOADED_BYTES - 1);
                    op = ($urandom_range(0, 1) == 0) ? fat12te_pkg::OP_READ_BYTE
                                                    : fat12te_pkg::OP_LOAD_BYTE;
                    push_beat(op, 0, 0, addr, $urandom_range(0, 255));
                    if (op == fat12te_pkg::OP_LOAD_BYTE && addr < 3)
                        restore_reserved();
                end
                else if (pick < 95)
                begin
                    op = 3'($urandom_range(0, 7));
                    idx = $urandom_range(0, 4095);
                    addr = ($urandom_range(0, 3) == 0) ? $urandom_range(TABLE_BYTES, 8191)
                                                      : $urandom_range(0, LOADED_BYTES - 1);
                    push_beat(op, idx, $urandom_range(0, 4095), addr, $urandom_range(0, 255));
                    if (op == fat12te_pkg::OP_FREE_CHAIN
                        || (op == fat12te_pkg::OP_WRITE_ENTRY && idx < 2)
                        || (op == fat12te_pkg::OP_LOAD_BYTE && addr < 3))
                        restore_reserved();
                end
                else
                begin
                    idx = $urandom_range(entry_limit - 1,
                                         (entry_limit > 4095) ? 4095 : entry_limit);
                    op = ($urandom_range(0, 1) == 0) ? fat12te_pkg::OP_READ_ENTRY
                                                    : fat12te_pkg::OP_WRITE_ENTRY;
                    push_beat(op, idx, $urandom_range(0, 4095), 0, 0);
                end
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Far beyond the slowest correct run of this stimulus.
    initial
    begin
        #100_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/fat12te_pkg.sv
rtl/fat12te_ctrl.sv
rtl/fat12te_dp.sv
rtl/fat12_table_engine.sv
test/fat12_table_checker.sv
test/tb_top.sv
